>>> src/sha512_pkg.sv
// SHA-512 package: shared types, initial hash values and round constants.
// No dependencies.
package sha512_pkg;

    localparam int WORD_W   = 64;
    localparam int ROUNDS_C = 80;

    // Kind of word passed from the front end to the compression engine.
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FINISH = 2'd1
    } word_kind_t;

    // One queue entry: a schedule word plus its kind.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        word_kind_t        kind;
    } queue_entry_t;

    localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [WORD_W-1:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

>>> src/sha512_front.sv
// SHA-512 front end: takes message items, counts bytes and appends padding.
// Depends on sha512_pkg.
module sha512_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [63:0]             in_word,
    input  logic [3:0]              in_bytes,
    input  logic                    in_last,
    output logic                    q_valid,
    input  logic                    q_ready,
    output sha512_pkg::queue_entry_t q_entry
);
    import sha512_pkg::*;

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_MARK,
        ST_ZERO,
        ST_LEN
    } fstate_t;

    fstate_t     state_reg;
    logic [3:0]  pos_reg;
    logic [63:0] total_reg;
    logic        len_hi_done_reg;

    logic [3:0]  nbytes;
    logic [63:0] total_sum;
    logic [63:0] mask;
    logic [63:0] tail_word;
    logic        take;

    assign in_ready = (state_reg == ST_TAKE) && q_ready;
    assign take     = in_valid && in_ready;

    // Saturate the byte count and build the masked, padded tail word.
    always_comb begin
        nbytes = in_last ? ((in_bytes > 4'd8) ? 4'd8 : in_bytes) : 4'd8;
        total_sum = total_reg + {60'd0, nbytes};
        mask = ~(64'hffff_ffff_ffff_ffff >> {nbytes, 3'b000});
        tail_word = (in_word & mask);
        if (nbytes != 4'd8) begin
            tail_word = tail_word | (64'h8000_0000_0000_0000 >> {nbytes, 3'b000});
        end
    end

    // Queue output word for the current state.
    always_comb begin
        q_entry.kind = KIND_DATA;
        q_entry.word = '0;
        q_valid      = 1'b0;
        case (state_reg)
            ST_TAKE: begin
                q_valid      = in_valid;
                q_entry.word = in_last ? tail_word : in_word;
            end
            ST_MARK: begin
                q_valid      = 1'b1;
                q_entry.word = 64'h8000_0000_0000_0000;
            end
            ST_ZERO: begin
                q_valid = 1'b1;
            end
            ST_LEN: begin
                q_valid = 1'b1;
                if (len_hi_done_reg) begin
                    q_entry.word = {total_reg[60:0], 3'b000};
                    q_entry.kind = KIND_FINISH;
                end else begin
                    q_entry.word = {61'd0, total_reg[63:61]};
                end
            end
            default: q_valid = 1'b0;
        endcase
    end

    // Padding sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_TAKE;
            pos_reg         <= '0;
            total_reg       <= '0;
            len_hi_done_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_TAKE: begin
                    if (take) begin
                        pos_reg   <= pos_reg + 4'd1;
                        total_reg <= total_sum;
                        if (in_last) begin
                            if (nbytes == 4'd8) begin
                                state_reg <= ST_MARK;
                            end else if (pos_reg + 4'd1 == 4'd14) begin
                                state_reg <= ST_LEN;
                            end else begin
                                state_reg <= ST_ZERO;
                            end
                        end
                    end
                end
                ST_MARK, ST_ZERO: begin
                    if (q_ready) begin
                        pos_reg <= pos_reg + 4'd1;
                        state_reg <= (pos_reg + 4'd1 == 4'd14) ? ST_LEN : ST_ZERO;
                    end
                end
                ST_LEN: begin
                    if (q_ready) begin
                        if (len_hi_done_reg) begin
                            state_reg       <= ST_TAKE;
                            pos_reg         <= '0;
                            total_reg       <= '0;
                            len_hi_done_reg <= 1'b0;
                        end else begin
                            pos_reg         <= pos_reg + 4'd1;
                            len_hi_done_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_TAKE;
            endcase
        end
    end

    // Length words only go out at block slots 14 and 15.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN) |-> (pos_reg == 4'd14 || pos_reg == 4'd15))
        else $error("length word at wrong slot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_TAKE) |-> !in_ready)
        else $error("input taken during padding");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ZERO) |-> (pos_reg != 4'd14))
        else $error("zero padding overran slot 14");
endmodule

>>> src/sha512_queue.sv
// SHA-512 two-entry queue between front end and compression engine.
// Depends on sha512_pkg.
module sha512_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_valid,
    output logic                     wr_ready,
    input  sha512_pkg::queue_entry_t wr_entry,
    output logic                     rd_valid,
    input  logic                     rd_ready,
    output sha512_pkg::queue_entry_t rd_entry
);
    import sha512_pkg::*;

    queue_entry_t mem_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   count_reg;
    logic         do_wr;
    logic         do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_entry = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            if (do_wr) wptr_reg <= ~wptr_reg;
            if (do_rd) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree with count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a write");
endmodule

>>> src/sha512_engine.sv
// SHA-512 compression engine: gathers blocks, runs one round a cycle, emits digest.
// Depends on sha512_pkg.
module sha512_engine #(
    parameter int ROUNDS = sha512_pkg::ROUNDS_C
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  sha512_pkg::queue_entry_t q_entry,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [63:0]              out_word,
    output logic [2:0]               out_index,
    output logic                     out_last
);
    import sha512_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } estate_t;

    estate_t       state_reg;
    logic [63:0]   h_reg [8];
    logic [63:0]   v_reg [8];
    logic [63:0]   w_reg [16];
    logic [3:0]    pos_reg;
    logic [RW-1:0] round_reg;
    logic          finish_reg;
    logic [2:0]    idx_reg;

    logic [63:0] w_t, a, b, s0, s1, w_new, t1, t2, e, x;
    logic [3:0]  t4;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction

    assign q_ready   = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word  = h_reg[idx_reg];
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 3'd7);

    // Schedule expansion and round function.
    always_comb begin
        t4 = round_reg[3:0];
        a  = w_reg[t4 - 4'd2];
        b  = w_reg[t4 - 4'd15];
        s1 = rotr(a, 19) ^ rotr(a, 61) ^ (a >> 6);
        s0 = rotr(b, 1) ^ rotr(b, 8) ^ (b >> 7);
        w_new = s1 + w_reg[t4 - 4'd7] + s0 + w_reg[t4];
        w_t = (round_reg >= RW'(16)) ? w_new : w_reg[t4];
        e = v_reg[4];
        x = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
             + ((e & v_reg[5]) ^ (~e & v_reg[6]))
             + ROUND_K[round_reg[6:0]] + w_t;
        t2 = (rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39))
             + ((x & v_reg[1]) ^ (x & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Control, working variables and chaining value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            pos_reg    <= '0;
            round_reg  <= '0;
            finish_reg <= 1'b0;
            idx_reg    <= '0;
            for (int j = 0; j < 8; j++) h_reg[j] <= INIT_HASH[j];
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (q_valid) begin
                        w_reg[pos_reg] <= q_entry.word;
                        pos_reg        <= pos_reg + 4'd1;
                        if (pos_reg == 4'd15) begin
                            finish_reg <= (q_entry.kind == KIND_FINISH);
                            round_reg  <= '0;
                            for (int j = 0; j < 8; j++) v_reg[j] <= h_reg[j];
                            state_reg  <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    w_reg[t4] <= w_t;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + RW'(1);
                    if (round_reg == RW'(ROUNDS - 1)) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) h_reg[j] <= h_reg[j] + v_reg[j];
                    idx_reg   <= '0;
                    state_reg <= finish_reg ? ST_EMIT : ST_LOAD;
                end
                ST_EMIT: begin
                    if (out_ready) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) begin
                            for (int j = 0; j < 8; j++) h_reg[j] <= INIT_HASH[j];
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (round_reg < RW'(ROUNDS)))
        else $error("round counter overran");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == RW'(ROUNDS - 1)) |=> (state_reg == ST_ADD))
        else $error("rounds did not end in the add step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (pos_reg == 4'd0))
        else $error("block gathered out of step");
endmodule

>>> src/sha512_hash_core_top.sv
// SHA-512 hash core top level: front end, queue and compression engine.
// Depends on sha512_pkg, sha512_front, sha512_queue, sha512_engine.
//
//  Channel | Dir | Ports                          | Carries
//  input   | in  | s_axis_tvalid/tready/tdata/... | message words, valid bytes, last
//  result  | out | m_axis_tvalid/tready/tdata/... | digest words 0..7, last on 7
//
// The engine runs one round per cycle: a block is loaded as 16 words, then runs
// the rounds and the add step, and no new words are taken until that is done.
// The message end adds two to eighteen padding words; the digest then leaves
// as eight items. Reset is synchronous on aresetn and restores the initial hash.
// A stall on the result side holds the engine; the queue lets the front end
// run ahead by two words.
module sha512_hash_core_top #(
    parameter int ROUNDS = sha512_pkg::ROUNDS_C
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_word
    input  logic [3:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // digest_index
    output logic        m_axis_tlast    // last_digest
);
    import sha512_pkg::*;

    logic         f_valid, f_ready, e_valid, e_ready;
    queue_entry_t f_entry, e_entry;

    sha512_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_word(s_axis_tdata), .in_bytes(s_axis_tuser), .in_last(s_axis_tlast),
        .q_valid(f_valid), .q_ready(f_ready), .q_entry(f_entry)
    );

    sha512_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_entry(f_entry),
        .rd_valid(e_valid), .rd_ready(e_ready), .rd_entry(e_entry)
    );

    sha512_engine #(.ROUNDS(ROUNDS)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(e_valid), .q_ready(e_ready), .q_entry(e_entry),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
    );
endmodule
